### rtl/bdh_pkg.sv
// Shared types and constants for the button debounce and hold detector.
package bdh_pkg;

   localparam int unsigned CfgWidth = 16;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned ScreenWidth = 3;
   localparam int unsigned CountWidth = 7;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
   localparam logic [CfgWidth-1:0] ShortPressReset = 16'd1000;
   localparam logic [CfgWidth-1:0] ResetHoldReset = 16'd9000;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [1:0] RegDebounce = 2'd0;
   localparam logic [1:0] RegShortPress = 2'd1;
   localparam logic [1:0] RegResetHold = 2'd2;

   // Seconds rounding: ceil(x / 1000) = floor((x + 999) / 1000), done as a
   // multiply by ceil(2^26 / 1000) and a shift; exact for x below 2^16.
   localparam logic [16:0] RoundUp = 17'd999;
   localparam logic [16:0] Recip = 17'd67109;
   localparam int unsigned RecipShift = 26;

   typedef enum logic [1:0] {
      CD_KEEP,
      CD_CLEAR,
      CD_LOAD
   } cd_op_type;

   typedef struct packed {
      logic [CfgWidth-1:0] debounce_ms;
      logic [CfgWidth-1:0] short_press_ms;
      logic [CfgWidth-1:0] reset_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [ScreenWidth-1:0] screen;
      cd_op_type cd_op;
      logic [CfgWidth-1:0] remaining;
      logic holding;
      logic pulse;
   } stage_type;

endpackage

### rtl/button_debounce_hold_detector_unit.sv
// Top level of the button debounce and hold detector.
//
//   channel  direction  beat contents
//   req      in         button_level, now_ms
//   rsp      out        screen_index, countdown_sec, holding, reset_request
//   csr      in/out     APB-style writes and reads of the three timing registers
//
// The button state is updated as a sample beat is taken, and the beat's control
// word is registered; the seconds rounding multiplier sits in the second stage.
// A new sample is accepted every cycle unless the output stalls. Synchronous reset
// restores the default timings and the released raw level, but sets the settled
// level to pressed. A stalled result holds its register; the first stage takes
// one more beat behind it, and then the input stalls until the result is taken.
module button_debounce_hold_detector_unit #(
   parameter int unsigned SCREEN_COUNT = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_button_level,
   input  logic [31:0] req_now_ms,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_screen_index,
   output logic [6:0] rsp_countdown_sec,
   output logic rsp_holding,
   output logic rsp_reset_request,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   bdh_pkg::cfg_type cfg;
   bdh_pkg::stage_type stage;
   logic stage_valid;
   logic stage_ready;

   bdh_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   bdh_track #(
      .SCREEN_COUNT(SCREEN_COUNT)
   ) u_track (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_button_level(req_button_level),
      .req_now_ms(req_now_ms),
      .stage_valid(stage_valid),
      .stage_ready(stage_ready),
      .stage(stage)
   );

   bdh_countdown u_countdown (
      .clock(clock),
      .reset(reset),
      .stage_valid(stage_valid),
      .stage_ready(stage_ready),
      .stage(stage),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_screen_index(rsp_screen_index),
      .rsp_countdown_sec(rsp_countdown_sec),
      .rsp_holding(rsp_holding),
      .rsp_reset_request(rsp_reset_request)
   );

endmodule

### rtl/bdh_csr.sv
// Configuration registers behind the APB-style port.
module bdh_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [bdh_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [bdh_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [bdh_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic csr_pready,
   output bdh_pkg::cfg_type cfg
);

   bdh_pkg::cfg_type cfg_ff;
   bdh_pkg::cfg_type cfg_in;
   logic [1:0] index;
   logic write_en;

   assign index = csr_paddr[3:2];
   assign write_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            bdh_pkg::RegDebounce: cfg_in.debounce_ms = csr_pwdata[15:0];
            bdh_pkg::RegShortPress: cfg_in.short_press_ms = csr_pwdata[15:0];
            bdh_pkg::RegResetHold: cfg_in.reset_hold_ms = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bdh_pkg::RegDebounce: csr_prdata = {16'd0, cfg_ff.debounce_ms};
         bdh_pkg::RegShortPress: csr_prdata = {16'd0, cfg_ff.short_press_ms};
         bdh_pkg::RegResetHold: csr_prdata = {16'd0, cfg_ff.reset_hold_ms};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= bdh_pkg::DebounceReset;
         cfg_ff.short_press_ms <= bdh_pkg::ShortPressReset;
         cfg_ff.reset_hold_ms <= bdh_pkg::ResetHoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/bdh_track.sv
// Debounce and hold tracking: updates the button state on each beat and
// registers the per-beat control word for the countdown stage.
module bdh_track #(
   parameter int unsigned SCREEN_COUNT = 2
) (
   input  logic clock,
   input  logic reset,
   input  bdh_pkg::cfg_type cfg,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_button_level,
   input  logic [bdh_pkg::TimeWidth-1:0] req_now_ms,
   output logic stage_valid,
   input  logic stage_ready,
   output bdh_pkg::stage_type stage
);

   logic prev_raw_ff, prev_raw_in;
   logic [bdh_pkg::TimeWidth-1:0] last_change_ff, last_change_in;
   logic stable_ff, stable_in;
   logic [bdh_pkg::TimeWidth-1:0] press_start_ff, press_start_in;
   logic hold_ff, hold_in;
   logic [bdh_pkg::ScreenWidth-1:0] screen_ff, screen_in;
   logic stage_valid_ff, stage_valid_in;
   bdh_pkg::stage_type stage_ff, stage_in;

   logic fire;
   logic changed;
   logic settled;
   logic [bdh_pkg::TimeWidth-1:0] since_change;
   logic [bdh_pkg::TimeWidth-1:0] held;
   logic [bdh_pkg::TimeWidth-1:0] remaining;
   logic [bdh_pkg::ScreenWidth:0] screen_inc;
   logic press_edge;
   logic release_edge;
   logic hold_mid;
   logic past_short;
   logic past_reset;

   assign fire = req_valid & req_ready;
   assign req_ready = ~stage_valid_ff | stage_ready;
   assign stage_valid = stage_valid_ff;
   assign stage = stage_ff;

   assign changed = req_button_level != prev_raw_ff;
   assign since_change = req_now_ms - last_change_ff;
   // A level that just changed never passes the debounce test: settled requires no change.
   assign settled = ~changed && (since_change > {16'd0, cfg.debounce_ms})
                    && (req_button_level != stable_ff);
   assign press_edge = settled & ~req_button_level & ~hold_ff;
   assign release_edge = settled & req_button_level & hold_ff;

   assign press_start_in = fire && press_edge ? req_now_ms : press_start_ff;
   assign held = req_now_ms - press_start_in;
   assign remaining = {16'd0, cfg.reset_hold_ms} - held;
   assign screen_inc = {1'b0, screen_ff} + 1'b1;

   assign hold_mid = (hold_ff | press_edge) & ~release_edge;
   assign past_short = held >= {16'd0, cfg.short_press_ms};
   assign past_reset = held >= {16'd0, cfg.reset_hold_ms};

   always_comb begin
      prev_raw_in = prev_raw_ff;
      last_change_in = last_change_ff;
      stable_in = stable_ff;
      hold_in = hold_ff;
      screen_in = screen_ff;
      stage_in = stage_ff;
      if (fire) begin
         prev_raw_in = req_button_level;
         if (changed) begin
            last_change_in = req_now_ms;
         end
         if (settled) begin
            stable_in = req_button_level;
         end
         stage_in.cd_op = bdh_pkg::CD_KEEP;
         stage_in.pulse = 1'b0;
         stage_in.remaining = remaining[bdh_pkg::CfgWidth-1:0];
         hold_in = hold_mid;
         if (release_edge) begin
            stage_in.cd_op = bdh_pkg::CD_CLEAR;
            if (!past_short) begin
               screen_in = (screen_inc == SCREEN_COUNT[bdh_pkg::ScreenWidth:0]) ?
                           '0 : screen_inc[bdh_pkg::ScreenWidth-1:0];
            end
         end
         // The hold is timed only while the settled level is pressed.
         if (hold_mid && !stable_in && past_short) begin
            stage_in.cd_op = bdh_pkg::CD_LOAD;
            if (past_reset) begin
               hold_in = 1'b0;
               stage_in.cd_op = bdh_pkg::CD_CLEAR;
               stage_in.pulse = 1'b1;
            end
         end
         stage_in.holding = hold_in;
         stage_in.screen = screen_in;
      end
   end

   assign stage_valid_in = fire | (stage_valid_ff & ~stage_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= 1'b1;
         last_change_ff <= '0;
         stable_ff <= 1'b0;
         press_start_ff <= '0;
         hold_ff <= 1'b0;
         screen_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         prev_raw_ff <= prev_raw_in;
         last_change_ff <= last_change_in;
         stable_ff <= stable_in;
         press_start_ff <= press_start_in;
         hold_ff <= hold_in;
         screen_ff <= screen_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

### rtl/bdh_countdown.sv
// Countdown stage: rounds the remaining hold time up to whole seconds and
// holds the result beat.
module bdh_countdown (
   input  logic clock,
   input  logic reset,
   input  logic stage_valid,
   output logic stage_ready,
   input  bdh_pkg::stage_type stage,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [bdh_pkg::ScreenWidth-1:0] rsp_screen_index,
   output logic [bdh_pkg::CountWidth-1:0] rsp_countdown_sec,
   output logic rsp_holding,
   output logic rsp_reset_request
);

   logic rsp_valid_ff, rsp_valid_in;
   logic [bdh_pkg::CountWidth-1:0] countdown_ff, countdown_in;
   logic [bdh_pkg::ScreenWidth-1:0] screen_ff;
   logic holding_ff;
   logic pulse_ff;
   logic advance;
   logic [16:0] rounded;
   logic [33:0] product;
   logic [bdh_pkg::CountWidth-1:0] seconds;

   assign stage_ready = ~rsp_valid_ff | rsp_ready;
   assign advance = stage_valid & stage_ready;

   assign rounded = {1'b0, stage.remaining} + bdh_pkg::RoundUp;
   assign product = rounded * bdh_pkg::Recip;
   assign seconds = product[bdh_pkg::RecipShift +: bdh_pkg::CountWidth];

   // The countdown register is both the kept state and the result payload,
   // so it only moves when a beat enters the output register.
   always_comb begin
      countdown_in = countdown_ff;
      if (advance) begin
         unique case (stage.cd_op)
            bdh_pkg::CD_KEEP: countdown_in = countdown_ff;
            bdh_pkg::CD_CLEAR: countdown_in = '0;
            bdh_pkg::CD_LOAD: countdown_in = seconds;
            default: countdown_in = countdown_ff;
         endcase
      end
   end

   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         countdown_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         screen_ff <= stage.screen;
         holding_ff <= stage.holding;
         pulse_ff <= stage.pulse;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_screen_index = screen_ff;
   assign rsp_countdown_sec = countdown_ff;
   assign rsp_holding = holding_ff;
   assign rsp_reset_request = pulse_ff;

   a_pulse_clears: assert property (@(posedge clock) disable iff (reset)
      stage_valid && stage.pulse |-> !stage.holding && stage.cd_op == bdh_pkg::CD_CLEAR)
      else $error("reset request without clearing the hold");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_holding |-> rsp_countdown_sec == '0)
      else $error("countdown nonzero while no hold is timed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_countdown_sec <= 7'd66)
      else $error("countdown above its maximum");

   a_load_holding: assert property (@(posedge clock) disable iff (reset)
      advance && stage.cd_op == bdh_pkg::CD_LOAD |=> rsp_holding)
      else $error("countdown loaded outside a hold");

endmodule
